// ===== hdl/mipsdec_pkg.sv =====
// Package for the MIPS III instruction decoder: instruction identifiers,
// unit classes, fault codes and the decode function for one instruction word.
// It depends on nothing else.
package mipsdec_pkg;

  typedef enum logic [7:0] {
    ID_LB, ID_LBU, ID_LD, ID_LDL, ID_LDR, ID_LH, ID_LHU, ID_LL, ID_LLD, ID_LW,
    ID_LWL, ID_LWR, ID_LWU,
    ID_SB, ID_SC, ID_SCD, ID_SD, ID_SDL, ID_SDR, ID_SH, ID_SW, ID_SWL, ID_SWR,
    ID_ADDI, ID_ADDIU, ID_ANDI, ID_DADDI, ID_DADDIU, ID_LUI, ID_ORI, ID_SLTI,
    ID_SLTIU, ID_XORI,
    ID_J, ID_JAL, ID_JALR, ID_JR,
    ID_BEQ, ID_BEQL, ID_BGTZ, ID_BGTZL, ID_BLEZ, ID_BLEZL, ID_BNE, ID_BNEL,
    ID_BGEZ, ID_BGEZAL, ID_BGEZALL, ID_BGEZL, ID_BLTZ, ID_BLTZAL, ID_BLTZALL,
    ID_BLTZL,
    ID_LDC1, ID_LWC1, ID_SDC1, ID_SWC1,
    ID_ADD, ID_ADDU, ID_AND, ID_DADD, ID_DADDU, ID_DSUB, ID_DSUBU, ID_NOR,
    ID_OR, ID_SLT, ID_SLTU, ID_SUB, ID_SUBU, ID_XOR,
    ID_DSLL, ID_DSLLV, ID_DSLL32, ID_DSRA, ID_DSRAV, ID_DSRA32, ID_DSRL,
    ID_DSRLV, ID_DSRL32, ID_SLL, ID_SLLV, ID_SRA, ID_SRAV, ID_SRL, ID_SRLV,
    ID_DDIV, ID_DDIVU, ID_DIV, ID_DIVU, ID_DMULT, ID_DMULTU, ID_MULT, ID_MULTU,
    ID_TEQ, ID_TGE, ID_TGEU, ID_TLT, ID_TLTU, ID_TNE,
    ID_TEQI, ID_TGEI, ID_TGEIU, ID_TLTI, ID_TLTIU, ID_TNEI,
    ID_MFHI, ID_MFLO, ID_MTHI, ID_MTLO,
    ID_BREAK, ID_SYNC, ID_SYSCALL, ID_CACHE,
    ID_ERET, ID_TLBP, ID_TLBR, ID_TLBWI, ID_TLBWR,
    ID_DMFC0, ID_DMTC0, ID_MFC0, ID_MTC0,
    ID_BC1F, ID_BC1FL, ID_BC1T, ID_BC1TL,
    ID_CFC1, ID_CTC1, ID_DMFC1, ID_DMTC1, ID_MFC1, ID_MTC1,
    ID_FABS, ID_FADD, ID_FDIV, ID_FMOV, ID_FMUL, ID_FNEG, ID_FSQRT, ID_FSUB,
    ID_CEIL_L, ID_CEIL_W, ID_CVT_D, ID_CVT_L, ID_CVT_S, ID_CVT_W, ID_FLOOR_L,
    ID_FLOOR_W, ID_ROUND_L, ID_ROUND_W, ID_TRUNC_L, ID_TRUNC_W,
    ID_FCMP,
    ID_NONE
  } instr_id_t;

  typedef enum logic [4:0] {
    CLS_LOAD, CLS_STORE, CLS_ALU_IMM, CLS_JUMP, CLS_BRANCH, CLS_FPU_LOAD,
    CLS_FPU_STORE, CLS_ALU_REG, CLS_SHIFT, CLS_MULDIV, CLS_TRAP_REG,
    CLS_TRAP_IMM, CLS_HILO, CLS_SYSTEM, CLS_CP0_CTL, CLS_CP0_MOVE,
    CLS_FPU_BRANCH, CLS_FPU_MOVE, CLS_FPU_ARITH, CLS_FPU_CVT, CLS_FPU_CMP,
    CLS_NONE
  } unit_class_t;

  typedef enum logic [1:0] {
    FAULT_NONE, FAULT_RESERVED, FAULT_FPU_UNIMPL, FAULT_COP0_INVALID
  } fault_code_t;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP1    = 6'h11;
  localparam logic [4:0] RS_COP0_CO = 5'h10;
  localparam logic [4:0] RS_COP1_BC = 5'h08;

  typedef struct packed {
    fault_code_t fault;
    unit_class_t cls;
    instr_id_t   id;
  } dec_t;

  function automatic unit_class_t class_of(input instr_id_t id);
    unit_class_t c;
    if      (id < ID_SB)    c = CLS_LOAD;
    else if (id < ID_ADDI)  c = CLS_STORE;
    else if (id < ID_J)     c = CLS_ALU_IMM;
    else if (id < ID_BEQ)   c = CLS_JUMP;
    else if (id < ID_LDC1)  c = CLS_BRANCH;
    else if (id < ID_SDC1)  c = CLS_FPU_LOAD;
    else if (id < ID_ADD)   c = CLS_FPU_STORE;
    else if (id < ID_DSLL)  c = CLS_ALU_REG;
    else if (id < ID_DDIV)  c = CLS_SHIFT;
    else if (id < ID_TEQ)   c = CLS_MULDIV;
    else if (id < ID_TEQI)  c = CLS_TRAP_REG;
    else if (id < ID_MFHI)  c = CLS_TRAP_IMM;
    else if (id < ID_BREAK) c = CLS_HILO;
    else if (id < ID_ERET)  c = CLS_SYSTEM;
    else if (id < ID_DMFC0) c = CLS_CP0_CTL;
    else if (id < ID_BC1F)  c = CLS_CP0_MOVE;
    else if (id < ID_CFC1)  c = CLS_FPU_BRANCH;
    else if (id < ID_FABS)  c = CLS_FPU_MOVE;
    else if (id < ID_CEIL_L) c = CLS_FPU_ARITH;
    else if (id < ID_FCMP)  c = CLS_FPU_CVT;
    else if (id < ID_NONE)  c = CLS_FPU_CMP;
    else                    c = CLS_NONE;
    return c;
  endfunction

  function automatic instr_id_t primary_id(input logic [5:0] op);
    instr_id_t id;
    case (op)
      6'h20: id = ID_LB;     6'h24: id = ID_LBU;    6'h37: id = ID_LD;
      6'h1A: id = ID_LDL;    6'h1B: id = ID_LDR;    6'h21: id = ID_LH;
      6'h25: id = ID_LHU;    6'h30: id = ID_LL;     6'h34: id = ID_LLD;
      6'h23: id = ID_LW;     6'h22: id = ID_LWL;    6'h26: id = ID_LWR;
      6'h27: id = ID_LWU;
      6'h28: id = ID_SB;     6'h38: id = ID_SC;     6'h3C: id = ID_SCD;
      6'h3F: id = ID_SD;     6'h2C: id = ID_SDL;    6'h2D: id = ID_SDR;
      6'h29: id = ID_SH;     6'h2B: id = ID_SW;     6'h2A: id = ID_SWL;
      6'h2E: id = ID_SWR;
      6'h08: id = ID_ADDI;   6'h09: id = ID_ADDIU;  6'h0C: id = ID_ANDI;
      6'h18: id = ID_DADDI;  6'h19: id = ID_DADDIU; 6'h0F: id = ID_LUI;
      6'h0D: id = ID_ORI;    6'h0A: id = ID_SLTI;   6'h0B: id = ID_SLTIU;
      6'h0E: id = ID_XORI;
      6'h02: id = ID_J;      6'h03: id = ID_JAL;
      6'h04: id = ID_BEQ;    6'h14: id = ID_BEQL;   6'h07: id = ID_BGTZ;
      6'h17: id = ID_BGTZL;  6'h06: id = ID_BLEZ;   6'h16: id = ID_BLEZL;
      6'h05: id = ID_BNE;    6'h15: id = ID_BNEL;
      6'h2F: id = ID_CACHE;
      6'h35: id = ID_LDC1;   6'h31: id = ID_LWC1;   6'h3D: id = ID_SDC1;
      6'h39: id = ID_SWC1;
      default: id = ID_NONE;
    endcase
    return id;
  endfunction

  function automatic instr_id_t special_id(input logic [5:0] fn);
    instr_id_t id;
    case (fn)
      6'h20: id = ID_ADD;    6'h21: id = ID_ADDU;   6'h24: id = ID_AND;
      6'h2C: id = ID_DADD;   6'h2D: id = ID_DADDU;  6'h2E: id = ID_DSUB;
      6'h2F: id = ID_DSUBU;  6'h27: id = ID_NOR;    6'h25: id = ID_OR;
      6'h2A: id = ID_SLT;    6'h2B: id = ID_SLTU;   6'h22: id = ID_SUB;
      6'h23: id = ID_SUBU;   6'h26: id = ID_XOR;
      6'h38: id = ID_DSLL;   6'h14: id = ID_DSLLV;  6'h3C: id = ID_DSLL32;
      6'h3B: id = ID_DSRA;   6'h17: id = ID_DSRAV;  6'h3F: id = ID_DSRA32;
      6'h3A: id = ID_DSRL;   6'h16: id = ID_DSRLV;  6'h3E: id = ID_DSRL32;
      6'h00: id = ID_SLL;    6'h04: id = ID_SLLV;   6'h03: id = ID_SRA;
      6'h07: id = ID_SRAV;   6'h02: id = ID_SRL;    6'h06: id = ID_SRLV;
      6'h1E: id = ID_DDIV;   6'h1F: id = ID_DDIVU;  6'h1A: id = ID_DIV;
      6'h1B: id = ID_DIVU;   6'h1C: id = ID_DMULT;  6'h1D: id = ID_DMULTU;
      6'h18: id = ID_MULT;   6'h19: id = ID_MULTU;
      6'h09: id = ID_JALR;   6'h08: id = ID_JR;
      6'h34: id = ID_TEQ;    6'h30: id = ID_TGE;    6'h31: id = ID_TGEU;
      6'h32: id = ID_TLT;    6'h33: id = ID_TLTU;   6'h36: id = ID_TNE;
      6'h10: id = ID_MFHI;   6'h12: id = ID_MFLO;   6'h11: id = ID_MTHI;
      6'h13: id = ID_MTLO;
      6'h0D: id = ID_BREAK;  6'h0F: id = ID_SYNC;   6'h0C: id = ID_SYSCALL;
      default: id = ID_NONE;
    endcase
    return id;
  endfunction

  function automatic instr_id_t regimm_id(input logic [4:0] rt);
    instr_id_t id;
    case (rt)
      5'h01: id = ID_BGEZ;   5'h11: id = ID_BGEZAL; 5'h13: id = ID_BGEZALL;
      5'h03: id = ID_BGEZL;  5'h00: id = ID_BLTZ;   5'h10: id = ID_BLTZAL;
      5'h12: id = ID_BLTZALL; 5'h02: id = ID_BLTZL;
      5'h0C: id = ID_TEQI;   5'h08: id = ID_TGEI;   5'h09: id = ID_TGEIU;
      5'h0A: id = ID_TLTI;   5'h0B: id = ID_TLTIU;  5'h0E: id = ID_TNEI;
      default: id = ID_NONE;
    endcase
    return id;
  endfunction

  function automatic instr_id_t fpu_id(input logic [5:0] fn);
    instr_id_t id;
    case (fn)
      6'h05: id = ID_FABS;   6'h00: id = ID_FADD;   6'h03: id = ID_FDIV;
      6'h06: id = ID_FMOV;   6'h02: id = ID_FMUL;   6'h07: id = ID_FNEG;
      6'h04: id = ID_FSQRT;  6'h01: id = ID_FSUB;
      6'h0A: id = ID_CEIL_L; 6'h0E: id = ID_CEIL_W; 6'h21: id = ID_CVT_D;
      6'h25: id = ID_CVT_L;  6'h20: id = ID_CVT_S;  6'h24: id = ID_CVT_W;
      6'h0B: id = ID_FLOOR_L; 6'h0F: id = ID_FLOOR_W; 6'h08: id = ID_ROUND_L;
      6'h0C: id = ID_ROUND_W; 6'h09: id = ID_TRUNC_L; 6'h0D: id = ID_TRUNC_W;
      default: id = ID_NONE;
    endcase
    return id;
  endfunction

  function automatic dec_t decode(input logic [31:0] w);
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [5:0]  fn;
    instr_id_t   id;
    fault_code_t fault;
    dec_t        d;
    op    = w[31:26];
    rs    = w[25:21];
    rt    = w[20:16];
    fn    = w[5:0];
    id    = ID_NONE;
    fault = FAULT_NONE;
    case (op)
      OP_SPECIAL: begin
        id = special_id(fn);
        if (id == ID_NONE) fault = FAULT_RESERVED;
      end
      OP_REGIMM: begin
        id = regimm_id(rt);
        if (id == ID_NONE) fault = FAULT_RESERVED;
      end
      OP_COP0: begin
        case (rs)
          RS_COP0_CO: begin
            case (fn)
              6'h18: id = ID_ERET;
              6'h08: id = ID_TLBP;
              6'h01: id = ID_TLBR;
              6'h02: id = ID_TLBWI;
              6'h06: id = ID_TLBWR;
              default: fault = FAULT_COP0_INVALID;
            endcase
          end
          5'h01: id = ID_DMFC0;
          5'h05: id = ID_DMTC0;
          5'h00: id = ID_MFC0;
          5'h04: id = ID_MTC0;
          default: fault = FAULT_RESERVED;
        endcase
      end
      OP_COP1: begin
        case (rs)
          RS_COP1_BC: begin
            case (rt)
              5'h00: id = ID_BC1F;
              5'h02: id = ID_BC1FL;
              5'h01: id = ID_BC1T;
              5'h03: id = ID_BC1TL;
              default: fault = FAULT_RESERVED;
            endcase
          end
          5'h02: id = ID_CFC1;
          5'h06: id = ID_CTC1;
          5'h01: id = ID_DMFC1;
          5'h05: id = ID_DMTC1;
          5'h00: id = ID_MFC1;
          5'h04: id = ID_MTC1;
          default: begin
            // Every function with both top bits set is a compare.
            if (fn[5:4] == 2'b11) begin
              id = ID_FCMP;
            end else begin
              id = fpu_id(fn);
              if (id == ID_NONE) fault = FAULT_FPU_UNIMPL;
            end
          end
        endcase
      end
      default: begin
        id = primary_id(op);
        if (id == ID_NONE) fault = FAULT_RESERVED;
      end
    endcase
    d.id    = id;
    d.cls   = class_of(id);
    d.fault = fault;
    return d;
  endfunction

endpackage

// ===== hdl/mips_instruction_decoder.sv =====
// Top level of the MIPS III instruction decoder: one stream in, one stream out.
// Depends on mipsdec_pkg for the identifiers and the decode function.

// Each item is one 32-bit instruction word; the decoder answers it with one
// result item holding the instruction identifier (154 for none), the unit
// class (21 for none) and a fault code. The decode is a single pass of
// combinational logic into the result register, so a result appears in the
// cycle after its item is accepted, and one item is taken every cycle as long
// as the result side keeps taking items.
module mips_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // instr_word[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // instr_id[7:0], unit_class[12:8], fault_code[14:13], 0
);

  logic                out_valid_r;
  mipsdec_pkg::dec_t   dec_r;
  mipsdec_pkg::dec_t   dec_nxt;
  logic                in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign dec_nxt   = mipsdec_pkg::decode(in_tdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, dec_r.fault, dec_r.cls, dec_r.id};

  a_fault_means_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (dec_r.fault != mipsdec_pkg::FAULT_NONE)
      |-> (dec_r.id == mipsdec_pkg::ID_NONE) && (dec_r.cls == mipsdec_pkg::CLS_NONE))
    else $error("Faulting result carries an instruction identifier.");

  a_none_means_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (dec_r.id == mipsdec_pkg::ID_NONE)
      |-> (dec_r.fault != mipsdec_pkg::FAULT_NONE))
    else $error("Result without an instruction has no fault code.");

  a_class_matches_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((dec_r.cls == mipsdec_pkg::CLS_NONE) == (dec_r.id == mipsdec_pkg::ID_NONE)))
    else $error("Unit class and instruction identifier disagree.");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("Accepted item produced no result.");

endmodule
